/* rtl/core/fbfl_pkg.sv */
// Shared types and constants for the fixed-size block free-list allocator.
package fbfl_pkg;

    // Pool size: number of equal-size blocks that the allocator manages.
    localparam int NUM_BLOCKS = 256;

    // Field widths of the command and result words.
    localparam int INDEX_W  = 8;
    localparam int OFFSET_W = 20;
    localparam int COUNT_W  = 9;
    localparam int TOTAL_W  = 32;
    localparam int BYTES_W  = 13;

    // Block size register: reset value and smallest size that takes effect.
    localparam logic [BYTES_W-1:0] BLOCK_BYTES_RESET = 13'd64;
    localparam logic [BYTES_W-1:0] MIN_BLOCK_BYTES   = 13'd8;

    // Register map (register index taken from the word address).
    localparam logic REG_BLOCK_BYTES = 1'b0;

    // Command codes.
    typedef enum logic {
        OP_ALLOC   = 1'b0,
        OP_RELEASE = 1'b1
    } opcode_t;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK           = 2'd0,
        ST_POOL_EMPTY   = 2'd1,
        ST_NULL_RELEASE = 2'd2,
        ST_NONE_ACTIVE  = 2'd3
    } status_t;

    // Top-level control: link initialization sweep, then normal operation.
    typedef enum logic [1:0] {
        CTL_INIT = 2'b01,
        CTL_RUN  = 2'b10
    } ctl_state_t;

endpackage

/* rtl/core/fbfl_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
module fbfl_ram #(
    parameter int WIDTH = 9,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port; a same-cycle write returns the old data.
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

/* rtl/core/fixed_block_free_list_allocator_core.sv */
// Fixed-size block free-list allocator: LIFO free list of block indexes in a link RAM.
//
// The block manages NUM_BLOCKS equal-size blocks. Each command word (allocate, or
// release of a block index) is taken at a clock edge with start high and busy low,
// and gives exactly one result word, shown for one cycle with done high after the
// input and result registers. The receiver cannot stall: a result must be taken in
// the cycle it is shown. One command is taken every cycle while busy is low; the link
// of the head block is kept prefetched from the link RAM (one read port, registered),
// so back-to-back allocates do not wait. After reset, busy stays high while the link
// RAM is swept to its initial chain (block i links to block i-1); block_bytes may be
// written during that time. The result carries a status, the granted index and byte
// offset (index times block size, low 20 bits), and the active, free, allocation and
// release counts after the command. Double releases are not checked.
module fixed_block_free_list_allocator_core (
    input  logic                            clk,
    input  logic                            rst_n,

    // Command port.
    input  logic                            start,
    output logic                            busy,
    input  logic                            opcode,
    input  logic                            block_present,
    input  logic [fbfl_pkg::INDEX_W-1:0]    release_index,

    // Result port.
    output logic                            done,
    output logic [1:0]                      status,
    output logic [fbfl_pkg::INDEX_W-1:0]    granted_index,
    output logic [fbfl_pkg::OFFSET_W-1:0]   granted_offset,
    output logic [fbfl_pkg::COUNT_W-1:0]    active_count,
    output logic [fbfl_pkg::COUNT_W-1:0]    idle_count,
    output logic [fbfl_pkg::TOTAL_W-1:0]    grant_total,
    output logic [fbfl_pkg::TOTAL_W-1:0]    release_total,

    // Configuration port.
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [2:0]                      paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);

    // Pool size, and the index, link and count widths that follow from it.
    localparam int NUM_BLOCKS = fbfl_pkg::NUM_BLOCKS;
    localparam int IW = $clog2(NUM_BLOCKS);
    localparam int LW = IW + 1;
    localparam int AW = $clog2(NUM_BLOCKS + 1);
    localparam int PW = LW + fbfl_pkg::BYTES_W;
    localparam logic [LW-1:0] LINK_NULL = {LW{1'b1}};

    // Control state and configuration.
    fbfl_pkg::ctl_state_t               ctl_reg, ctl_next;
    logic [IW-1:0]                      init_cnt_reg, init_cnt_next;
    logic [fbfl_pkg::BYTES_W-1:0]       block_bytes_reg;

    // Input stage.
    logic                               s1_valid_reg;
    logic                               s1_op_reg;
    logic                               s1_present_reg;
    logic [fbfl_pkg::INDEX_W-1:0]       s1_rel_reg;

    // Free list state.
    logic [LW-1:0]                      head_reg, head_next;
    logic                               sel_saved_reg, sel_saved_next;
    logic [LW-1:0]                      saved_link_reg, saved_link_next;
    logic [AW-1:0]                      active_reg, active_next;
    logic [fbfl_pkg::TOTAL_W-1:0]       grants_reg, grants_next;
    logic [fbfl_pkg::TOTAL_W-1:0]       releases_reg, releases_next;

    // Result registers.
    logic                               done_reg;
    logic [1:0]                         status_reg, status_next;
    logic [fbfl_pkg::INDEX_W-1:0]       gidx_reg, gidx_next;
    logic [fbfl_pkg::OFFSET_W-1:0]      goff_reg, goff_next;
    logic [fbfl_pkg::COUNT_W-1:0]       active_out_reg;
    logic [fbfl_pkg::COUNT_W-1:0]       idle_out_reg;

    // Link RAM connections.
    logic                               ram_we;
    logic [IW-1:0]                      ram_waddr;
    logic [LW-1:0]                      ram_wdata;
    logic [IW-1:0]                      ram_raddr;
    logic [LW-1:0]                      ram_rdata;

    // Step decode.
    logic                               accept;
    logic                               cfg_write;
    logic [LW-1:0]                      head_link;
    logic                               rel_in_range;
    logic                               alloc_ok;
    logic                               rel_ok;
    logic [fbfl_pkg::BYTES_W-1:0]       eff_bytes;
    logic [PW-1:0]                      offset_prod;

    assign busy      = (ctl_reg != fbfl_pkg::CTL_RUN);
    assign accept    = start && !busy;
    assign cfg_write = psel && penable && pwrite && pready;
    assign pready    = 1'b1;

    // Register read-back.
    always_comb
    begin
        prdata = 32'd0;
        if (paddr[2] == fbfl_pkg::REG_BLOCK_BYTES)
        begin
            prdata = 32'(block_bytes_reg);
        end
    end

    // Block size register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_bytes_reg <= fbfl_pkg::BLOCK_BYTES_RESET;
        end
        else if (cfg_write && (paddr[2] == fbfl_pkg::REG_BLOCK_BYTES))
        begin
            block_bytes_reg <= pwdata[fbfl_pkg::BYTES_W-1:0];
        end
    end

    // Initialization sweep sequencer.
    always_comb
    begin
        ctl_next      = ctl_reg;
        init_cnt_next = init_cnt_reg;
        case (ctl_reg)
            fbfl_pkg::CTL_INIT:
            begin
                init_cnt_next = init_cnt_reg + 1'b1;
                if (init_cnt_reg == IW'(NUM_BLOCKS - 1))
                begin
                    ctl_next = fbfl_pkg::CTL_RUN;
                end
            end
            fbfl_pkg::CTL_RUN:
            begin
                ctl_next = fbfl_pkg::CTL_RUN;
            end
            default:
            begin
                ctl_next      = fbfl_pkg::CTL_INIT;
                init_cnt_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg      <= fbfl_pkg::CTL_INIT;
            init_cnt_reg <= '0;
        end
        else
        begin
            ctl_reg      <= ctl_next;
            init_cnt_reg <= init_cnt_next;
        end
    end

    // Input stage: capture the command word.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_op_reg      <= opcode;
            s1_present_reg <= block_present;
            s1_rel_reg     <= release_index;
        end
    end

    // Link of the current head: null for a null head, the saved link after a release or reset, else the RAM word.
    always_comb
    begin
        if (head_reg >= LW'(NUM_BLOCKS))
        begin
            head_link = LINK_NULL;
        end
        else if (sel_saved_reg)
        begin
            head_link = saved_link_reg;
        end
        else
        begin
            head_link = ram_rdata;
        end
    end

    // Command decode.
    assign rel_in_range = (32'(s1_rel_reg) < 32'(NUM_BLOCKS));
    assign alloc_ok     = s1_valid_reg && (s1_op_reg == fbfl_pkg::OP_ALLOC)
                          && (active_reg < AW'(NUM_BLOCKS));
    assign rel_ok       = s1_valid_reg && (s1_op_reg == fbfl_pkg::OP_RELEASE)
                          && s1_present_reg && rel_in_range && (active_reg != '0);

    // Byte offset of the popped block.
    assign eff_bytes   = (block_bytes_reg < fbfl_pkg::MIN_BLOCK_BYTES)
                         ? fbfl_pkg::MIN_BLOCK_BYTES : block_bytes_reg;
    assign offset_prod = PW'(head_reg) * PW'(eff_bytes);

    // Free list update and result word.
    always_comb
    begin
        head_next       = head_reg;
        sel_saved_next  = sel_saved_reg;
        saved_link_next = saved_link_reg;
        active_next     = active_reg;
        grants_next     = grants_reg;
        releases_next   = releases_reg;
        status_next     = fbfl_pkg::ST_OK;
        gidx_next       = '0;
        goff_next       = '0;

        if (alloc_ok)
        begin
            head_next      = head_link;
            sel_saved_next = 1'b0;
            active_next    = active_reg + 1'b1;
            grants_next    = grants_reg + 1'b1;
            gidx_next      = fbfl_pkg::INDEX_W'(head_reg);
            goff_next      = fbfl_pkg::OFFSET_W'(offset_prod);
        end
        else if (rel_ok)
        begin
            head_next       = LW'(s1_rel_reg);
            sel_saved_next  = 1'b1;
            saved_link_next = head_reg;
            active_next     = active_reg - 1'b1;
            releases_next   = releases_reg + 1'b1;
        end

        if (s1_op_reg == fbfl_pkg::OP_ALLOC)
        begin
            if (!alloc_ok)
            begin
                status_next = fbfl_pkg::ST_POOL_EMPTY;
            end
        end
        else if (!s1_present_reg || !rel_in_range)
        begin
            status_next = fbfl_pkg::ST_NULL_RELEASE;
        end
        else if (active_reg == '0)
        begin
            status_next = fbfl_pkg::ST_NONE_ACTIVE;
        end
    end

    // Link RAM: the read address is the head of the next cycle except on a release, when it stays the current head.
    always_comb
    begin
        ram_raddr = alloc_ok ? head_link[IW-1:0] : head_reg[IW-1:0];
        ram_we    = 1'b0;
        ram_waddr = init_cnt_reg;
        ram_wdata = (init_cnt_reg == '0) ? LINK_NULL : LW'(init_cnt_reg - 1'b1);
        if (ctl_reg == fbfl_pkg::CTL_INIT)
        begin
            ram_we = 1'b1;
        end
        else if (rel_ok)
        begin
            ram_we    = 1'b1;
            ram_waddr = IW'(s1_rel_reg);
            ram_wdata = head_reg;
        end
    end

    fbfl_ram #(
        .WIDTH (LW),
        .DEPTH (NUM_BLOCKS)
    ) u_link_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Free list state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg       <= LW'(NUM_BLOCKS - 1);
            sel_saved_reg  <= 1'b1;
            saved_link_reg <= LW'(NUM_BLOCKS - 2);
            active_reg     <= '0;
            grants_reg     <= '0;
            releases_reg   <= '0;
        end
        else
        begin
            head_reg       <= head_next;
            sel_saved_reg  <= sel_saved_next;
            saved_link_reg <= saved_link_next;
            active_reg     <= active_next;
            grants_reg     <= grants_next;
            releases_reg   <= releases_next;
        end
    end

    // Result strobe.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= s1_valid_reg;
        end
    end

    // Result word registers.
    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
        begin
            status_reg     <= status_next;
            gidx_reg       <= gidx_next;
            goff_reg       <= goff_next;
            active_out_reg <= fbfl_pkg::COUNT_W'(active_next);
            idle_out_reg   <= fbfl_pkg::COUNT_W'(AW'(NUM_BLOCKS) - active_next);
        end
    end

    assign done           = done_reg;
    assign status         = status_reg;
    assign granted_index  = gidx_reg;
    assign granted_offset = goff_reg;
    assign active_count   = active_out_reg;
    assign idle_count     = idle_out_reg;
    assign grant_total    = grants_reg;
    assign release_total  = releases_reg;

endmodule

/* bench/testbench.sv */
// Self-checking bench for the block free-list allocator: table-driven and random words.
`timescale 1ns / 100ps

module testbench;

    localparam int POOL_SIZE = fbfl_pkg::NUM_BLOCKS;

    // One result word as the block reports it.
    typedef struct packed {
        fbfl_pkg::status_t                st;
        logic [fbfl_pkg::INDEX_W-1:0]     idx;
        logic [fbfl_pkg::OFFSET_W-1:0]    off;
        logic [fbfl_pkg::COUNT_W-1:0]     act;
        logic [fbfl_pkg::COUNT_W-1:0]     idle;
        logic [fbfl_pkg::TOTAL_W-1:0]     grants;
        logic [fbfl_pkg::TOTAL_W-1:0]     rels;
    } reply_t;

    // One row of the directed table; typed rows carry their result word.
    typedef struct {
        fbfl_pkg::opcode_t                op;
        logic                             pres;
        logic [fbfl_pkg::INDEX_W-1:0]     idx;
        bit                               typed;
        reply_t                           want;
    } pool_row_t;

    logic                                 clk = 1'b0;
    logic                                 rst_n;
    logic                                 start;
    logic                                 busy;
    logic                                 opcode;
    logic                                 block_present;
    logic [fbfl_pkg::INDEX_W-1:0]         release_index;
    logic                                 done;
    logic [1:0]                           status;
    logic [fbfl_pkg::INDEX_W-1:0]         granted_index;
    logic [fbfl_pkg::OFFSET_W-1:0]        granted_offset;
    logic [fbfl_pkg::COUNT_W-1:0]         active_count;
    logic [fbfl_pkg::COUNT_W-1:0]         idle_count;
    logic [fbfl_pkg::TOTAL_W-1:0]         grant_total;
    logic [fbfl_pkg::TOTAL_W-1:0]         release_total;
    logic                                 psel;
    logic                                 penable;
    logic                                 pwrite;
    logic [2:0]                           paddr;
    logic [31:0]                          pwdata;
    logic [31:0]                          prdata;
    logic                                 pready;

    // Shadow of the allocator state.
    logic [8:0]                           link_mem [POOL_SIZE];
    logic [8:0]                           head_blk;
    logic [fbfl_pkg::COUNT_W-1:0]         held_count;
    logic [fbfl_pkg::TOTAL_W-1:0]         grant_cnt;
    logic [fbfl_pkg::TOTAL_W-1:0]         release_cnt;
    logic [fbfl_pkg::BYTES_W-1:0]         size_reg;

    // Words still owed by the block, oldest first, and blocks we believe are out.
    reply_t                               reply_q [$];
    logic [fbfl_pkg::INDEX_W-1:0]         held_q [$];
    pool_row_t                            pool_rows [$];
    int unsigned                          errors = 0;

    fixed_block_free_list_allocator_core u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .opcode         (opcode),
        .block_present  (block_present),
        .release_index  (release_index),
        .done           (done),
        .status         (status),
        .granted_index  (granted_index),
        .granted_offset (granted_offset),
        .active_count   (active_count),
        .idle_count     (idle_count),
        .grant_total    (grant_total),
        .release_total  (release_total),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Hard stop in case the block hangs.
    initial
    begin
        #5_000_000;
        $display("Regression FAIL");
        $finish;
    end

    // Put the shadow state into its post-reset form.
    function automatic void pool_clear();
        link_mem[0] = 9'h1FF;
        for (int i = 1; i < POOL_SIZE; i++)
        begin
            link_mem[i] = 9'(i - 1);
        end
        head_blk    = 9'(POOL_SIZE - 1);
        held_count  = '0;
        grant_cnt   = '0;
        release_cnt = '0;
        size_reg    = fbfl_pkg::BLOCK_BYTES_RESET;
    endfunction

    // Append one row to the directed table.
    function automatic void add_row(input fbfl_pkg::opcode_t op, input logic pres,
                                    input logic [fbfl_pkg::INDEX_W-1:0] idx,
                                    input bit typed, input reply_t want);
        pool_row_t row;
        row.op    = op;
        row.pres  = pres;
        row.idx   = idx;
        row.typed = typed;
        row.want  = want;
        pool_rows.insert(pool_rows.size(), row);
    endfunction

    // Pop or push the free list for one command word and form its result word.
    function automatic reply_t grant_or_return(input fbfl_pkg::opcode_t op, input logic pres,
                                               input logic [fbfl_pkg::INDEX_W-1:0] idx);
        reply_t                       r;
        logic [fbfl_pkg::BYTES_W-1:0] eff;
        logic [8:0]                   blk;
        r    = '0;
        r.st = fbfl_pkg::ST_OK;
        if (op == fbfl_pkg::OP_ALLOC)
        begin
            if (int'(held_count) >= POOL_SIZE)
            begin
                r.st = fbfl_pkg::ST_POOL_EMPTY;
            end
            else
            begin
                blk      = head_blk;
                eff      = (size_reg < fbfl_pkg::MIN_BLOCK_BYTES)
                           ? fbfl_pkg::MIN_BLOCK_BYTES : size_reg;
                head_blk = (int'(blk) < POOL_SIZE) ? link_mem[blk[7:0]] : 9'h1FF;
                r.idx    = blk[fbfl_pkg::INDEX_W-1:0];
                r.off    = fbfl_pkg::OFFSET_W'(int'(blk) * int'(eff));
                grant_cnt++;
                held_count++;
            end
        end
        else if (!pres || int'(idx) >= POOL_SIZE)
        begin
            r.st = fbfl_pkg::ST_NULL_RELEASE;
        end
        else if (held_count == 0)
        begin
            r.st = fbfl_pkg::ST_NONE_ACTIVE;
        end
        else
        begin
            link_mem[idx] = head_blk;
            head_blk      = {1'b0, idx};
            release_cnt++;
            held_count--;
        end
        r.act    = held_count;
        r.idle   = fbfl_pkg::COUNT_W'(POOL_SIZE - int'(held_count));
        r.grants = grant_cnt;
        r.rels   = release_cnt;
        return r;
    endfunction

    task automatic check_field(input string name, input longint unsigned want,
                               input longint unsigned got);
        if (want != got)
        begin
            errors++;
            $error("%s: expected %0d, got %0d", name, want, got);
        end
    endtask

    // Hand one command word to the block after an optional gap and log its result word.
    task automatic send_word(input fbfl_pkg::opcode_t op, input logic pres,
                             input logic [fbfl_pkg::INDEX_W-1:0] idx,
                             input int gap, input bit typed, input reply_t want);
        reply_t pred;
        int     k;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start         <= 1'b1;
        opcode        <= op;
        block_present <= pres;
        release_index <= idx;
        @(posedge clk);
        while (busy) @(posedge clk);
        pred = grant_or_return(op, pres, idx);
        if (op == fbfl_pkg::OP_ALLOC && pred.st == fbfl_pkg::ST_OK)
        begin
            held_q.insert(held_q.size(), pred.idx);
        end
        else if (op == fbfl_pkg::OP_RELEASE && pred.st == fbfl_pkg::ST_OK)
        begin
            for (k = 0; k < held_q.size(); k++)
            begin
                if (held_q[k] == idx)
                begin
                    held_q.delete(k);
                    break;
                end
            end
        end
        reply_q.insert(reply_q.size(), typed ? want : pred);
    endtask

    // One register access: setup, access, then return to idle.
    task automatic apb_xfer(input logic wr, input logic [2:0] addr, input logic [31:0] wdata,
                            output logic [31:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    // Compare each result word with the oldest one owed.
    always @(posedge clk)
    begin : watch_results
        reply_t want;
        if (done === 1'b1)
        begin
            if (reply_q.size() == 0)
            begin
                errors++;
                $error("result word with none expected");
            end
            else
            begin
                want = reply_q.pop_front();
                check_field("status", want.st, status);
                check_field("granted_index", want.idx, granted_index);
                check_field("granted_offset", want.off, granted_offset);
                check_field("active_count", want.act, active_count);
                check_field("idle_count", want.idle, idle_count);
                check_field("grant_total", want.grants, grant_total);
                check_field("release_total", want.rels, release_total);
            end
        end
    end

    initial
    begin : stimulus
        logic [fbfl_pkg::BYTES_W-1:0] phase_size [7];
        int                           alloc_pct [7];
        logic [31:0]                  rd;
        int                           gap;
        int                           roll;
        int                           pick;
        reply_t                       blank;

        rst_n         = 1'b0;
        start         = 1'b0;
        opcode        = fbfl_pkg::OP_ALLOC;
        block_present = 1'b0;
        release_index = '0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        blank         = '0;
        pool_clear();

        phase_size = '{13'd8191, 13'd0, 13'd4096, 13'd7, 13'd8, 13'd1000, 13'd1};
        alloc_pct  = '{90, 100, 20, 60, 97, 5, 50};
        phase_size[5] = fbfl_pkg::BYTES_W'($urandom_range(4096, 8));

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // The block size register comes out of reset at its default.
        apb_xfer(1'b0, {fbfl_pkg::REG_BLOCK_BYTES, 2'b00}, 32'd0, rd);
        check_field("block_bytes", fbfl_pkg::BLOCK_BYTES_RESET, rd[fbfl_pkg::BYTES_W-1:0]);

        // Directed table at the reset block size of 64 bytes.
        add_row(fbfl_pkg::OP_ALLOC, 1'b0, 8'd0, 1'b1,
                '{fbfl_pkg::ST_OK, 8'd255, 20'd16320, 9'd1, 9'd255, 32'd1, 32'd0});
        add_row(fbfl_pkg::OP_RELEASE, 1'b0, 8'd0, 1'b1,
                '{fbfl_pkg::ST_NULL_RELEASE, 8'd0, 20'd0, 9'd1, 9'd255, 32'd1, 32'd0});
        add_row(fbfl_pkg::OP_RELEASE, 1'b0, 8'd255, 1'b1,
                '{fbfl_pkg::ST_NULL_RELEASE, 8'd0, 20'd0, 9'd1, 9'd255, 32'd1, 32'd0});
        add_row(fbfl_pkg::OP_RELEASE, 1'b1, 8'd255, 1'b1,
                '{fbfl_pkg::ST_OK, 8'd0, 20'd0, 9'd0, 9'd256, 32'd1, 32'd1});
        // Releases with nothing handed out are flagged and change nothing.
        add_row(fbfl_pkg::OP_RELEASE, 1'b1, 8'd0, 1'b1,
                '{fbfl_pkg::ST_NONE_ACTIVE, 8'd0, 20'd0, 9'd0, 9'd256, 32'd1, 32'd1});
        add_row(fbfl_pkg::OP_RELEASE, 1'b1, 8'd255, 1'b1,
                '{fbfl_pkg::ST_NONE_ACTIVE, 8'd0, 20'd0, 9'd0, 9'd256, 32'd1, 32'd1});
        add_row(fbfl_pkg::OP_ALLOC, 1'b1, 8'd255, 1'b1,
                '{fbfl_pkg::ST_OK, 8'd255, 20'd16320, 9'd1, 9'd255, 32'd2, 32'd1});
        add_row(fbfl_pkg::OP_ALLOC, 1'b0, 8'd0, 1'b1,
                '{fbfl_pkg::ST_OK, 8'd254, 20'd16256, 9'd2, 9'd254, 32'd3, 32'd1});
        add_row(fbfl_pkg::OP_ALLOC, 1'b1, 8'd255, 1'b0, blank);
        // Release of a block that was never handed out goes through unchecked.
        add_row(fbfl_pkg::OP_RELEASE, 1'b1, 8'd0, 1'b0, blank);
        add_row(fbfl_pkg::OP_ALLOC, 1'b0, 8'd0, 1'b0, blank);
        add_row(fbfl_pkg::OP_RELEASE, 1'b1, 8'd254, 1'b0, blank);
        // Double release of the same block.
        add_row(fbfl_pkg::OP_RELEASE, 1'b1, 8'd254, 1'b0, blank);
        add_row(fbfl_pkg::OP_ALLOC, 1'b0, 8'd0, 1'b0, blank);
        add_row(fbfl_pkg::OP_ALLOC, 1'b1, 8'd170, 1'b0, blank);
        add_row(fbfl_pkg::OP_RELEASE, 1'b0, 8'd170, 1'b0, blank);
        add_row(fbfl_pkg::OP_RELEASE, 1'b1, 8'd85, 1'b0, blank);
        add_row(fbfl_pkg::OP_ALLOC, 1'b0, 8'd0, 1'b0, blank);

        foreach (pool_rows[r])
        begin
            gap = (r < 9) ? 0 : $urandom_range(17);
            send_word(pool_rows[r].op, pool_rows[r].pres, pool_rows[r].idx, gap,
                      pool_rows[r].typed, pool_rows[r].want);
        end

        // Random phases, each at its own block size and allocate/release mix.
        for (int ph = 0; ph < 7; ph++)
        begin
            start <= 1'b0;
            while (reply_q.size() != 0) @(posedge clk);
            apb_xfer(1'b1, {fbfl_pkg::REG_BLOCK_BYTES, 2'b00}, 32'(phase_size[ph]), rd);
            size_reg = phase_size[ph];
            apb_xfer(1'b0, {fbfl_pkg::REG_BLOCK_BYTES, 2'b00}, 32'd0, rd);
            check_field("block_bytes", phase_size[ph], rd[fbfl_pkg::BYTES_W-1:0]);

            for (int n = 0; n < 160; n++)
            begin
                // Alternate back-to-back stretches with stretches of random gaps.
                gap  = (((n / 32) % 2) == 1) ? 0 : $urandom_range(17);
                roll = $urandom_range(99);
                if (roll < alloc_pct[ph])
                begin
                    send_word(fbfl_pkg::OP_ALLOC, 1'($urandom_range(1)),
                              8'($urandom_range(255)), gap, 1'b0, blank);
                end
                else
                begin
                    roll = $urandom_range(99);
                    if (roll < 80 && held_q.size() != 0)
                    begin
                        pick = $urandom_range(held_q.size() - 1);
                        send_word(fbfl_pkg::OP_RELEASE, 1'b1, held_q[pick], gap, 1'b0,
                                  blank);
                    end
                    else if (roll < 88)
                    begin
                        send_word(fbfl_pkg::OP_RELEASE, 1'b0, 8'($urandom_range(255)), gap,
                                  1'b0, blank);
                    end
                    else
                    begin
                        send_word(fbfl_pkg::OP_RELEASE, 1'b1, 8'($urandom_range(255)), gap,
                                  1'b0, blank);
                    end
                end
            end
        end

        // Drain: wait for every owed word, then idle to catch strays.
        start <= 1'b0;
        while (reply_q.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);
        if (errors == 0)
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

/* filelist.f */
rtl/core/fbfl_pkg.sv
rtl/core/fbfl_ram.sv
rtl/core/fixed_block_free_list_allocator_core.sv
bench/testbench.sv
